/* rtl/escape_sequence_decoder_macros.svh */
// Assertion macros shared by the escape sequence decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escape decoder check failed");

// Next-cycle implication, checked outside reset.
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escape decoder check failed");

`endif

/* rtl/esd_pkg.sv */
// Package for the escape sequence decoder: mode codes, byte constants and
// the word types passed between the decode logic and the result queue.
`timescale 1ns / 1ps

package esd_pkg;

   localparam int MODE_W = 3;
   localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CARET  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ESC    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_OCT1   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_OCT2   = 3'd4;

   localparam int ACC_W = 6;

   localparam logic [7:0] CHAR_CARET     = 8'h5E;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CARET_OFFSET   = 8'h40;
   localparam logic [7:0] STOP_RESET     = 8'h20;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Register map.
   localparam logic REG_STOP_CHAR = 1'b0;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_marker;
      logic       ended_by_stop;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0]  count;
      result_type  res0;
      result_type  res1;
   } push_type;

   typedef struct packed {
      logic [MODE_W-1:0] next_mode;
      logic [ACC_W-1:0]  next_acc;
      push_type          push;
   } decode_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic                  room_for_pair;
   } fifo_status_type;

endpackage

/* rtl/escape_sequence_decoder.sv */
// Escape sequence decoder top level. An accepted byte is held in the input
// stage register, then decoded and written into the result queue, which drives
// the result port from its storage. Throughput: one byte per cycle while bytes
// yield at most one word and the result side takes them; the four-word result
// queue absorbs sparse two-word bytes, and a steady run of them stalls input.
// Reset (synchronous, active high) returns to normal mode, clears the octal
// value, empties the queue and sets the stop byte to space.
`timescale 1ns / 1ps

module escape_sequence_decoder (
   input  logic        clock,
   input  logic        reset,
   // Input bytes
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   // Result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_marker,
   output logic        rsp_ended_by_stop,
   output logic        rsp_last_of_run,
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   `include "escape_sequence_decoder_macros.svh"

   logic [7:0]                    stop_char_ff;
   logic                          stage_valid_ff, stage_valid_in;
   logic [7:0]                    stage_byte_ff;
   logic [esd_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [esd_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic                          advance;
   logic                          req_take;
   logic                          csr_write;
   esd_pkg::decode_type           dec;
   esd_pkg::push_type             push;
   esd_pkg::result_type           rd_word;
   esd_pkg::fifo_status_type      fifo_status;

   // Register port: one register at byte offset zero, no wait states.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == esd_pkg::REG_STOP_CHAR) ? {24'h0, stop_char_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_char_ff <= esd_pkg::STOP_RESET;
      end else if (csr_write && paddr[2] == esd_pkg::REG_STOP_CHAR) begin
         stop_char_ff <= pwdata[7:0];
      end
   end

   // Input stage: hold one byte; advance it into the decoder whenever the
   // queue can take a full pair of words, so a new byte may enter the same
   // cycle the held one leaves.
   assign advance   = stage_valid_ff && fifo_status.room_for_pair;
   assign req_ready = !stage_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_byte_ff <= req_in_byte;
      end
   end

   esd_decode u_decode (
      .mode      (mode_ff),
      .acc       (acc_ff),
      .in_byte   (stage_byte_ff),
      .stop_char (stop_char_ff),
      .dec       (dec)
   );

   // Commit the decode only on advance; otherwise hold the mode and push nothing.
   assign mode_in = advance ? dec.next_mode : mode_ff;
   assign acc_in  = advance ? dec.next_acc : acc_ff;

   always_comb begin
      push = dec.push;
      if (!advance) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= esd_pkg::MODE_NORMAL;
         acc_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
      end
   end

   // Result queue drives the output channel directly from its storage.
   esd_result_fifo u_result_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .rd_word  (rd_word),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .status   (fifo_status)
   );

   assign rsp_out_byte      = rd_word.out_byte;
   assign rsp_end_marker    = rd_word.end_marker;
   assign rsp_ended_by_stop = rd_word.ended_by_stop;
   assign rsp_last_of_run   = rd_word.last_of_run;

   // The queue never holds more words than it has slots.
   `ESD_ASSERT_IMPLY(a_fifo_bound, clock, reset, 1'b1, fifo_status.count <= esd_pkg::FIFO_CNT_W'(esd_pkg::FIFO_DEPTH))
   // An octal value only lives while octal digits are pending.
   `ESD_ASSERT_IMPLY(a_acc_idle, clock, reset, mode_ff != esd_pkg::MODE_OCT1 && mode_ff != esd_pkg::MODE_OCT2, acc_ff == '0)
   // An end marker carries no byte and always closes the run of its byte.
   `ESD_ASSERT_IMPLY(a_end_last, clock, reset, rsp_valid && rsp_end_marker, rsp_last_of_run && rsp_out_byte == 8'h00)

endmodule

/* rtl/esd_decode.sv */
// Combinational escape decode: one raw byte plus the current mode gives up
// to two result words and the next mode. Depends on esd_pkg.
`timescale 1ns / 1ps

module esd_decode (
   input  logic [esd_pkg::MODE_W-1:0] mode,
   input  logic [esd_pkg::ACC_W-1:0]  acc,
   input  logic [7:0]                 in_byte,
   input  logic [7:0]                 stop_char,
   output esd_pkg::decode_type        dec
);

   logic                       is_octal;
   logic [2:0]                 digit;
   logic                       plain_emit;
   esd_pkg::result_type        plain_res;
   logic [esd_pkg::MODE_W-1:0] plain_mode;
   logic [7:0]                 letter_byte;
   esd_pkg::result_type        res0;
   esd_pkg::result_type        res1;
   logic [1:0]                 count;

   assign is_octal = (in_byte[7:3] == 5'b00110);
   assign digit    = in_byte[2:0];

   // Byte handled as in normal mode.
   always_comb begin
      plain_emit = 1'b1;
      plain_mode = esd_pkg::MODE_NORMAL;
      plain_res  = '0;
      if (in_byte == 8'h00) begin
         plain_res.end_marker = 1'b1;
      end else if (in_byte == stop_char) begin
         plain_res.end_marker    = 1'b1;
         plain_res.ended_by_stop = 1'b1;
      end else if (in_byte == esd_pkg::CHAR_CARET) begin
         plain_emit = 1'b0;
         plain_mode = esd_pkg::MODE_CARET;
      end else if (in_byte == esd_pkg::CHAR_BACKSLASH) begin
         plain_emit = 1'b0;
         plain_mode = esd_pkg::MODE_ESC;
      end else begin
         plain_res.out_byte = in_byte;
      end
   end

   always_comb begin
      case (in_byte)
         8'h6E:   letter_byte = 8'h0A;
         8'h72:   letter_byte = 8'h0D;
         8'h74:   letter_byte = 8'h09;
         8'h62:   letter_byte = 8'h08;
         8'h66:   letter_byte = 8'h0C;
         default: letter_byte = in_byte;
      endcase
   end

   always_comb begin
      res0              = '0;
      res1              = plain_res;
      count             = 2'd0;
      dec.next_mode     = esd_pkg::MODE_NORMAL;
      dec.next_acc      = acc;
      unique case (mode)
         esd_pkg::MODE_CARET: begin
            if (in_byte == 8'h00) begin
               res0.out_byte = esd_pkg::CHAR_CARET;
               count         = 2'd2;
               dec.next_acc  = '0;
            end else begin
               res0.out_byte = 8'(in_byte - esd_pkg::CARET_OFFSET);
               count         = 2'd1;
            end
         end
         esd_pkg::MODE_ESC: begin
            if (in_byte == 8'h00) begin
               res0         = plain_res;
               count        = 2'd1;
               dec.next_acc = '0;
            end else if (is_octal) begin
               dec.next_mode = esd_pkg::MODE_OCT1;
               dec.next_acc  = {3'b000, digit};
            end else begin
               res0.out_byte = letter_byte;
               count         = 2'd1;
            end
         end
         esd_pkg::MODE_OCT1: begin
            if (is_octal) begin
               dec.next_mode = esd_pkg::MODE_OCT2;
               dec.next_acc  = {acc[2:0], digit};
            end else begin
               res0.out_byte = {5'b00000, acc[2:0]};
               count         = plain_emit ? 2'd2 : 2'd1;
               dec.next_mode = plain_mode;
               dec.next_acc  = '0;
            end
         end
         esd_pkg::MODE_OCT2: begin
            dec.next_acc = '0;
            if (is_octal) begin
               res0.out_byte = {acc[4:0], digit};
               count         = 2'd1;
            end else begin
               res0.out_byte = {2'b00, acc};
               count         = plain_emit ? 2'd2 : 2'd1;
               dec.next_mode = plain_mode;
            end
         end
         default: begin
            res0          = plain_res;
            count         = plain_emit ? 2'd1 : 2'd0;
            dec.next_mode = plain_mode;
            dec.next_acc  = '0;
         end
      endcase
      // Mark the final word of this byte.
      res0.last_of_run = (count == 2'd1);
      res1.last_of_run = 1'b1;
      dec.push.count   = count;
      dec.push.res0    = res0;
      dec.push.res1    = res1;
   end

endmodule

/* rtl/esd_result_fifo.sv */
// Small result queue: takes up to two words per cycle, gives one per cycle
// on a valid/ready channel. Depends on esd_pkg.
`timescale 1ns / 1ps

module esd_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  esd_pkg::push_type        push,
   output esd_pkg::result_type      rd_word,
   output logic                     rd_valid,
   input  logic                     rd_ready,
   output esd_pkg::fifo_status_type status
);

   esd_pkg::result_type              mem_ff [esd_pkg::FIFO_DEPTH];
   logic [esd_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [esd_pkg::FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [esd_pkg::FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [esd_pkg::FIFO_PTR_W-1:0]   wr_ptr_next;
   logic                             pop;

   assign rd_valid    = (count_ff != '0);
   assign rd_word     = mem_ff[rd_ptr_ff];
   assign pop         = rd_valid && rd_ready;
   assign wr_ptr_next = wr_ptr_ff + esd_pkg::FIFO_PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + esd_pkg::FIFO_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + esd_pkg::FIFO_PTR_W'(pop);
   assign count_in  = count_ff + esd_pkg::FIFO_CNT_W'(push.count)
                      - esd_pkg::FIFO_CNT_W'(pop);

   assign status.count         = count_ff;
   assign status.room_for_pair =
      (count_ff <= esd_pkg::FIFO_CNT_W'(esd_pkg::FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.res1;
      end
   end

endmodule

/* test/tb_escape_sequence_decoder.sv */
// Self-checking bench for escape_sequence_decoder: a directed table, then
// random tokens under several stop bytes and flow-control mixes.
// Depends on esd_pkg and the escape_sequence_decoder RTL only.
`timescale 1ns / 1ps

module tb_escape_sequence_decoder;
   import esd_pkg::*;

   localparam logic [7:0] DIGIT_ZERO  = 8'h30;
   localparam logic [7:0] DIGIT_SEVEN = 8'h37;
   localparam logic [2:0] STOP_ADDR   = {REG_STOP_CHAR, 2'b00};
   localparam int         PHASE_COUNT = 6;
   localparam int         PHASE_ITEMS = 300;

   // One directed step: either a raw byte or a stop byte write to zero.
   typedef struct packed {
      logic       is_cfg;
      logic       typed;
      logic [7:0] value;
      result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_marker;
   logic        rsp_ended_by_stop;
   logic        rsp_last_of_run;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [2:0]  paddr       = 3'd0;
   logic [31:0] pwdata      = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   // Decoder copy: mode, octal value so far and the stop byte.
   logic [MODE_W-1:0] dec_mode  = MODE_NORMAL;
   logic [ACC_W-1:0]  dec_acc   = '0;
   logic [7:0]        stop_byte = STOP_RESET;

   result_type   expected_words[$];
   result_type   got_word;
   stim_row_type steps[$];
   logic [7:0]   token_bytes[$];
   int           errors    = 0;
   int           idle_pct  = 0;
   int           stall_pct = 0;
   int           items     = 0;

   escape_sequence_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_byte(rsp_out_byte),
      .rsp_end_marker(rsp_end_marker), .rsp_ended_by_stop(rsp_ended_by_stop),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- decoder

   function automatic void emit_word(logic [7:0] v, logic em, logic bs);
      expected_words.push_back('{out_byte: v, end_marker: em, ended_by_stop: bs,
                                 last_of_run: 1'b0});
   endfunction

   // Handle a byte as if no escape were pending. A zero byte wins over a
   // zero stop byte, and the stop byte wins over caret and backslash.
   function automatic void plain_byte(logic [7:0] b);
      dec_mode = MODE_NORMAL;
      dec_acc  = '0;
      if (b == 8'h00) begin
         emit_word(8'h00, 1'b1, 1'b0);
      end else if (b == stop_byte) begin
         emit_word(8'h00, 1'b1, 1'b1);
      end else if (b == CHAR_CARET) begin
         dec_mode = MODE_CARET;
      end else if (b == CHAR_BACKSLASH) begin
         dec_mode = MODE_ESC;
      end else begin
         emit_word(b, 1'b0, 1'b0);
      end
   endfunction

   // Advance the decoder by one byte and queue the words it yields,
   // flagging the final one of the run.
   function automatic void decode_byte(logic [7:0] b);
      int  before_cnt;
      logic octal;
      before_cnt = expected_words.size();
      octal      = (b >= DIGIT_ZERO) && (b <= DIGIT_SEVEN);
      case (dec_mode)
         MODE_CARET: begin
            if (b == 8'h00) begin
               // caret at end of string comes out as itself
               emit_word(CHAR_CARET, 1'b0, 1'b0);
               plain_byte(b);
            end else begin
               emit_word(b - CARET_OFFSET, 1'b0, 1'b0);
               dec_mode = MODE_NORMAL;
            end
         end
         MODE_ESC: begin
            if (b == 8'h00) begin
               plain_byte(b);
            end else if (octal) begin
               dec_acc  = {3'b000, b[2:0]};
               dec_mode = MODE_OCT1;
            end else begin
               case (b)
                  "n":     emit_word(8'h0A, 1'b0, 1'b0);
                  "r":     emit_word(8'h0D, 1'b0, 1'b0);
                  "t":     emit_word(8'h09, 1'b0, 1'b0);
                  "b":     emit_word(8'h08, 1'b0, 1'b0);
                  "f":     emit_word(8'h0C, 1'b0, 1'b0);
                  default: emit_word(b, 1'b0, 1'b0);
               endcase
               dec_mode = MODE_NORMAL;
            end
         end
         MODE_OCT1: begin
            if (octal) begin
               dec_acc  = {dec_acc[2:0], b[2:0]};
               dec_mode = MODE_OCT2;
            end else begin
               emit_word({5'b00000, dec_acc[2:0]}, 1'b0, 1'b0);
               plain_byte(b);
            end
         end
         MODE_OCT2: begin
            if (octal) begin
               // third digit: keep the low 8 bits of the 9-bit value
               emit_word({dec_acc[4:0], b[2:0]}, 1'b0, 1'b0);
               dec_mode = MODE_NORMAL;
               dec_acc  = '0;
            end else begin
               emit_word({2'b00, dec_acc}, 1'b0, 1'b0);
               plain_byte(b);
            end
         end
         default: plain_byte(b);
      endcase
      if (expected_words.size() > before_cnt)
         expected_words[expected_words.size() - 1].last_of_run = 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one byte; hold valid and the byte until accepted. When typed,
   // replace the decoder's words for this byte with the one written in the
   // table. Nothing here consumes time after acceptance, so the result
   // monitor cannot pop in between.
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input result_type want);
      int before_cnt;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      before_cnt = expected_words.size();
      decode_byte(b);
      if (typed) begin
         while (expected_words.size() > before_cnt) void'(expected_words.pop_back());
         expected_words.push_back(want);
      end
      items++;
   endtask

   // Drop valid, wait for every expected word, then let any byte that
   // yields no word (caret, backslash, octal digit) work through.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register access with a setup and an access phase; a read checks the stop byte.
   task automatic csr_access(input logic wr, input logic [7:0] v);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= STOP_ADDR;
      pwdata  <= {24'h000000, v};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (wr) begin
         stop_byte = v;
      end else if (prdata[7:0] !== stop_byte) begin
         $error("stop_char: expected %h, got %h", stop_byte, prdata[7:0]);
         errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Build one token: mostly well-formed escapes with random content,
   // some raw noise, usually closed by the stop byte or end of string.
   function automatic void make_token();
      int pieces;
      int kind;
      int digits;
      token_bytes.delete();
      pieces = $urandom_range(6, 1);
      for (int i = 0; i < pieces; i++) begin
         kind = $urandom_range(99);
         if (kind < 25) begin
            token_bytes.push_back(8'($urandom_range(255, 1)));
         end else if (kind < 40) begin
            token_bytes.push_back(CHAR_CARET);
            token_bytes.push_back(8'($urandom_range(255)));
         end else if (kind < 55) begin
            token_bytes.push_back(CHAR_BACKSLASH);
            case ($urandom_range(4))
               0:       token_bytes.push_back("n");
               1:       token_bytes.push_back("r");
               2:       token_bytes.push_back("t");
               3:       token_bytes.push_back("b");
               default: token_bytes.push_back("f");
            endcase
         end else if (kind < 75) begin
            token_bytes.push_back(CHAR_BACKSLASH);
            digits = $urandom_range(3, 1);
            for (int d = 0; d < digits; d++)
               token_bytes.push_back(DIGIT_ZERO + 8'($urandom_range(7)));
         end else if (kind < 85) begin
            token_bytes.push_back(CHAR_BACKSLASH);
            token_bytes.push_back(8'($urandom_range(255)));
         end else begin
            token_bytes.push_back(8'($urandom_range(255)));
         end
      end
      kind = $urandom_range(9);
      if (kind < 5)
         token_bytes.push_back(stop_byte);
      else if (kind < 8)
         token_bytes.push_back(8'h00);
   endfunction

   // ---------------------------------------------------------------- checks

   // Drive the result side's ready at the falling edge from the stall rate.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Match each accepted word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: out_byte %h end_marker %b ended_by_stop %b last %b",
                   rsp_out_byte, rsp_end_marker, rsp_ended_by_stop, rsp_last_of_run);
            errors++;
         end else begin
            got_word = expected_words.pop_front();
            if (rsp_out_byte !== got_word.out_byte) begin
               $error("out_byte: expected %h, got %h", got_word.out_byte, rsp_out_byte);
               errors++;
            end
            if (rsp_end_marker !== got_word.end_marker) begin
               $error("end_marker: expected %b, got %b",
                      got_word.end_marker, rsp_end_marker);
               errors++;
            end
            if (rsp_ended_by_stop !== got_word.ended_by_stop) begin
               $error("ended_by_stop: expected %b, got %b",
                      got_word.ended_by_stop, rsp_ended_by_stop);
               errors++;
            end
            if (rsp_last_of_run !== got_word.last_of_run) begin
               $error("last_of_run: expected %b, got %b",
                      got_word.last_of_run, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic stim_row_type byte_row(logic [7:0] v);
      return '{is_cfg: 1'b0, typed: 1'b0, value: v, want: '0};
   endfunction

   function automatic stim_row_type word_row(logic [7:0] v, logic [7:0] ob, logic em,
                                             logic bs);
      return '{is_cfg: 1'b0, typed: 1'b1, value: v,
               want: '{out_byte: ob, end_marker: em, ended_by_stop: bs,
                       last_of_run: 1'b1}};
   endfunction

   initial begin
      logic [7:0] phase_stop [PHASE_COUNT];
      int         phase_idle [PHASE_COUNT];
      int         phase_stall[PHASE_COUNT];
      phase_stop  = '{8'h20, 8'h00, 8'hFF, CHAR_CARET, CHAR_BACKSLASH, 8'h00};
      phase_idle  = '{0, 87, 0, 12, 0, 12};
      phase_stall = '{0, 0, 87, 12, 0, 12};

      // Directed table, stop byte at its reset value of space.
      steps.push_back(word_row(8'hFF, 8'hFF, 1'b0, 1'b0));
      steps.push_back(word_row(STOP_RESET, 8'h00, 1'b1, 1'b1));
      steps.push_back(word_row(8'h00, 8'h00, 1'b1, 1'b0));
      // caret at end of string: the caret, then the end marker
      steps.push_back(byte_row(CHAR_CARET));
      steps.push_back(byte_row(8'h00));
      // caret swallows the stop byte
      steps.push_back(byte_row(CHAR_CARET));
      steps.push_back(word_row(STOP_RESET, 8'hE0, 1'b0, 1'b0));
      // dangling backslash is dropped
      steps.push_back(byte_row(CHAR_BACKSLASH));
      steps.push_back(word_row(8'h00, 8'h00, 1'b1, 1'b0));
      // escaped stop byte is literal
      steps.push_back(byte_row(CHAR_BACKSLASH));
      steps.push_back(word_row(STOP_RESET, 8'h20, 1'b0, 1'b0));
      steps.push_back(byte_row(CHAR_BACKSLASH));
      steps.push_back(word_row("n", 8'h0A, 1'b0, 1'b0));
      steps.push_back(byte_row(CHAR_BACKSLASH));
      steps.push_back(word_row("f", 8'h0C, 1'b0, 1'b0));
      // raw newline after backslash passes through
      steps.push_back(byte_row(CHAR_BACKSLASH));
      steps.push_back(word_row(8'h0A, 8'h0A, 1'b0, 1'b0));
      // three digits, truncated to a byte
      steps.push_back(byte_row(CHAR_BACKSLASH));
      steps.push_back(byte_row(DIGIT_SEVEN));
      steps.push_back(byte_row(DIGIT_SEVEN));
      steps.push_back(word_row(DIGIT_SEVEN, 8'hFF, 1'b0, 1'b0));
      // short escapes: one digit then a letter, two digits then end of string
      steps.push_back(byte_row(CHAR_BACKSLASH));
      steps.push_back(byte_row(DIGIT_ZERO + 8'd1));
      steps.push_back(byte_row("x"));
      steps.push_back(byte_row(CHAR_BACKSLASH));
      steps.push_back(byte_row(DIGIT_ZERO + 8'd1));
      steps.push_back(byte_row(DIGIT_ZERO + 8'd2));
      steps.push_back(byte_row(8'h00));
      // zero stop byte: a zero still reads as end of string
      steps.push_back('{is_cfg: 1'b1, typed: 1'b0, value: 8'h00, want: '0});
      steps.push_back(word_row(8'h00, 8'h00, 1'b1, 1'b0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Check the stop byte's reset value.
      csr_access(1'b0, 8'h00);

      foreach (steps[i]) begin
         if (steps[i].is_cfg) begin
            settle();
            csr_access(1'b1, steps[i].value);
            csr_access(1'b0, 8'h00);
         end else begin
            send_byte(steps[i].value, steps[i].typed, steps[i].want);
         end
      end

      // Random tokens, one stop byte and flow-control mix per phase.
      phase_stop[PHASE_COUNT - 1] = 8'($urandom_range(255));
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         csr_access(1'b1, phase_stop[p]);
         csr_access(1'b0, 8'h00);
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         items     = 0;
         while (items < PHASE_ITEMS) begin
            make_token();
            foreach (token_bytes[k]) send_byte(token_bytes[k], 1'b0, '0);
         end
      end

      // Drain, then give the block time to show any stray word.
      settle();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
